@@ hw/rtl/bakf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bakf_pkg;

    localparam int FRAC_BITS = 16;

    // Multiplier operands carry the sum of two covariance terms, hence 34 bits.
    localparam int OPD_W  = 34;
    localparam int PROD_W = 2 * OPD_W;
    localparam int ACC_W  = 54;

    localparam int DIV_NUM_W = 48;
    localparam int DIV_DEN_W = 34;

    localparam int DELTA_W = 20;
    localparam int DT_W    = 17;

    localparam logic [31:0] DT_MAX_US = 32'd1000000;

    // The time step is (delta * 2^(FRAC_BITS-5) + 15625) / 31250, taken as a
    // multiplication by a reciprocal that is exact for numerators below 2^31.
    localparam logic [30:0] DT_ROUND = 31'd15625;
    localparam logic [31:0] DT_RECIP = 32'd2251799814;
    localparam int          DT_SHIFT = 46;

    localparam logic [25:0] NOISE_LOW  = 26'd7;
    localparam logic [25:0] NOISE_HIGH = 26'd6553600;
    localparam logic [25:0] MEAS_LOW   = 26'd7;
    localparam logic [25:0] MEAS_HIGH  = 26'd65536000;
    localparam logic [25:0] GATE_LOW   = 26'd6554;
    localparam logic [25:0] GATE_HIGH  = 26'd65536000;

    localparam logic [22:0] ALT_NOISE_RST  = 23'd6554;
    localparam logic [22:0] VEL_NOISE_RST  = 23'd65536;
    localparam logic [25:0] MEAS_NOISE_RST = 26'd65536;
    localparam logic [25:0] GATE_RST       = 26'd655360;
    localparam logic signed [31:0] COV_RST = 32'sd262144;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 26;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALT_NOISE  = 2'd0,
        CFG_VEL_NOISE  = 2'd1,
        CFG_MEAS_NOISE = 2'd2,
        CFG_GATE       = 2'd3
    } t_cfg_idx;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_START,
        ST_DT_DIV,
        ST_DT2,
        ST_ALT,
        ST_AA1,
        ST_AA2,
        ST_AA3,
        ST_AVA,
        ST_VV,
        ST_CORR,
        ST_GATE,
        ST_K0_DIV,
        ST_K1_DIV,
        ST_C_ALT,
        ST_C_SPD,
        ST_C_VA,
        ST_C_VV,
        ST_C_AA,
        ST_C_AV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [31:0]        timestamp_us;
        logic signed [31:0] baro_altitude;
        logic               baro_valid;
        logic               sensor_ok;
        logic               failsafe;
    } t_sample;

    typedef struct packed {
        logic signed [31:0] altitude;
        logic signed [31:0] vertical_speed;
        logic               estimate_valid;
        logic               filter_started;
        logic signed [31:0] innovation;
        logic               rejected;
    } t_result;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic all_one;
        logic all_zero;
        all_one  = &v[ACC_W-1:31];
        all_zero = ~|v[ACC_W-1:31];
        if (all_one || all_zero) begin
            return v[31:0];
        end else if (v[ACC_W-1]) begin
            return 32'sh80000000;
        end else begin
            return 32'sh7FFFFFFF;
        end
    endfunction

    function automatic logic [25:0] clampu(input logic [25:0] v, input logic [25:0] lo,
                                           input logic [25:0] hi);
        if (v < lo) begin
            return lo;
        end else if (v > hi) begin
            return hi;
        end else begin
            return v;
        end
    endfunction

    // Quotient magnitude is limited to 2^31 and then given its sign; a positive 2^31 saturates to 2^31-1.
    function automatic logic signed [31:0] gain_from_quot(input logic [DIV_NUM_W-1:0] q,
                                                         input logic neg);
        logic [32:0] qc;
        qc = (q > DIV_NUM_W'(33'h100000000 >> 1)) ? 33'h080000000 : q[32:0];
        if (neg) begin
            return 32'(-qc);
        end else if (qc[31]) begin
            return 32'sh7FFFFFFF;
        end else begin
            return $signed(qc[31:0]);
        end
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/bakf_stream_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface bakf_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/baro_altitude_kalman_filter_core.sv @@
// Barometric altitude and vertical speed estimator, two-state Kalman filter.
// Samples arrive as requests on i_sample (valid/ready); each yields exactly
// one result request on o_result. Register writes go through i_cfg_wr_en,
// i_cfg_index and i_cfg_data and are meant to be issued while idle.
// The filter runs on one shared two-stage multiplier and one shared
// restoring divider under a sequencer, so one sample is taken at a time.
// A sample before seeding or a seeding sample goes straight to its result;
// a sample with a prediction runs seven multiplications first, and an
// accepted correction adds the two gain divisions and six more.
// The divider runs once for each of the two gains, one quotient bit per
// cycle over 48 bits; there are thirteen multiplications in all, and the
// time step is taken by reciprocal multiplication.
// The result sits in an output register; a new sample can be taken in the
// cycle after it is loaded, while it waits. If the receiver stalls, the next
// result holds the sequencer in its final step until the register frees up.
// After reset the registers hold their defaults, the covariance is 4.0 on
// the diagonal, the estimates are zero and the filter is not seeded.
`timescale 1ns / 1ps
`default_nettype none

module baro_altitude_kalman_filter_core
    import bakf_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_wr_en,
    input  wire [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data,
    bakf_stream_if.sink           i_sample,
    bakf_stream_if.source         o_result
);

    t_state r_state;
    t_state n_state;

    t_sample r_smp;
    logic [22:0] r_cfg_aqn;
    logic [22:0] r_cfg_vqn;
    logic [25:0] r_cfg_meas;
    logic [25:0] r_cfg_gate;

    logic               r_started;
    logic [31:0]        r_last_time;
    logic signed [31:0] r_alt;
    logic signed [31:0] r_spd;
    logic signed [31:0] r_paa;
    logic signed [31:0] r_pav;
    logic signed [31:0] r_pva;
    logic signed [31:0] r_pvv;
    logic signed [31:0] r_innov;
    logic               r_rej;

    logic [DELTA_W-1:0]      r_delta;
    logic [DT_W-1:0]         r_dt;
    logic [DT_W-1:0]         r_dt2;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [OPD_W-1:0] r_s;
    logic signed [31:0]      r_k0;
    logic signed [31:0]      r_k1;
    logic                    r_issued;
    logic                    r_out_valid;
    t_result                 r_out;

    logic                    w_mul_start;
    logic signed [OPD_W-1:0] w_mul_a;
    logic signed [OPD_W-1:0] w_mul_b;
    logic                    w_mul_done;
    logic signed [ACC_W-1:0] w_mul_res;
    logic                    w_div_start;
    logic [DIV_NUM_W-1:0]    w_div_num;
    logic [DIV_DEN_W-1:0]    w_div_den;
    logic                    w_div_done;
    logic [DIV_NUM_W-1:0]    w_div_quot;

    logic                    w_accept;
    logic [31:0]             w_delta;
    logic                    w_do_predict;
    logic [25:0]             w_qa;
    logic [25:0]             w_qv;
    logic [25:0]             w_meas;
    logic [25:0]             w_gate;
    logic signed [OPD_W-1:0] w_s;
    logic [31:0]             w_innov_mag;
    logic                    w_rej;
    logic [31:0]             w_mag_paa;
    logic [31:0]             w_mag_pva;
    logic                    w_out_free;
    logic signed [OPD_W-1:0] w_opd_dt;
    logic signed [OPD_W-1:0] w_opd_dt2;
    logic [30:0]             w_dt_num;
    logic [62:0]             w_dt_prod;

    assign w_accept     = i_sample.valid && (r_state == ST_IDLE);
    assign w_delta      = r_smp.timestamp_us - r_last_time;
    assign w_do_predict = (w_delta != 32'd0) && (w_delta <= DT_MAX_US);
    assign w_qa         = clampu({3'b000, r_cfg_aqn}, NOISE_LOW, NOISE_HIGH);
    assign w_qv         = clampu({3'b000, r_cfg_vqn}, NOISE_LOW, NOISE_HIGH);
    assign w_meas       = clampu(r_cfg_meas, MEAS_LOW, MEAS_HIGH);
    assign w_gate       = clampu(r_cfg_gate, GATE_LOW, GATE_HIGH);
    assign w_s          = OPD_W'(r_paa) + $signed({{(OPD_W - 26){1'b0}}, w_meas});
    assign w_innov_mag  = r_innov[31] ? 32'(-r_innov) : 32'(r_innov);
    assign w_rej        = w_innov_mag > {6'b000000, w_gate};
    assign w_mag_paa    = r_paa[31] ? 32'(-r_paa) : 32'(r_paa);
    assign w_mag_pva    = r_pva[31] ? 32'(-r_pva) : 32'(r_pva);
    assign w_out_free   = !r_out_valid || o_result.ready;
    assign w_opd_dt     = $signed({{(OPD_W - DT_W){1'b0}}, r_dt});
    assign w_opd_dt2    = $signed({{(OPD_W - DT_W){1'b0}}, r_dt2});
    assign w_dt_num     = (31'(r_delta) << (FRAC_BITS - 5)) + DT_ROUND;
    assign w_dt_prod    = 63'(w_dt_num) * 63'(DT_RECIP);

    bakf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_res   (w_mul_res)
    );

    bakf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_START;
            end
            ST_START: begin
                if (!r_started) begin
                    n_state = ST_OUT;
                end else if (w_do_predict) begin
                    n_state = ST_DT_DIV;
                end else begin
                    n_state = ST_CORR;
                end
            end
            ST_DT_DIV: n_state = ST_DT2;
            ST_DT2:    if (w_mul_done) n_state = ST_ALT;
            ST_ALT:    if (w_mul_done) n_state = ST_AA1;
            ST_AA1:    if (w_mul_done) n_state = ST_AA2;
            ST_AA2:    if (w_mul_done) n_state = ST_AA3;
            ST_AA3:    if (w_mul_done) n_state = ST_AVA;
            ST_AVA:    if (w_mul_done) n_state = ST_VV;
            ST_VV:     if (w_mul_done) n_state = ST_CORR;
            ST_CORR: begin
                n_state = r_smp.baro_valid ? ST_GATE : ST_OUT;
            end
            ST_GATE: begin
                if (w_rej || (w_s <= 0)) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_K0_DIV;
                end
            end
            ST_K0_DIV: if (w_div_done) n_state = ST_K1_DIV;
            ST_K1_DIV: if (w_div_done) n_state = ST_C_ALT;
            ST_C_ALT:  if (w_mul_done) n_state = ST_C_SPD;
            ST_C_SPD:  if (w_mul_done) n_state = ST_C_VA;
            ST_C_VA:   if (w_mul_done) n_state = ST_C_VV;
            ST_C_VV:   if (w_mul_done) n_state = ST_C_AA;
            ST_C_AA:   if (w_mul_done) n_state = ST_C_AV;
            ST_C_AV:   if (w_mul_done) n_state = ST_OUT;
            ST_OUT: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Shared unit requests and operand selection.
    always_comb begin
        w_mul_start = 1'b0;
        w_mul_a     = '0;
        w_mul_b     = '0;
        w_div_start = 1'b0;
        w_div_num   = '0;
        w_div_den   = '0;
        unique case (r_state)
            ST_K0_DIV: begin
                w_div_start = !r_issued;
                w_div_num   = (DIV_NUM_W'(w_mag_paa) << FRAC_BITS)
                            + DIV_NUM_W'(r_s[OPD_W-1:1]);
                w_div_den   = DIV_DEN_W'(r_s);
            end
            ST_K1_DIV: begin
                w_div_start = !r_issued;
                w_div_num   = (DIV_NUM_W'(w_mag_pva) << FRAC_BITS)
                            + DIV_NUM_W'(r_s[OPD_W-1:1]);
                w_div_den   = DIV_DEN_W'(r_s);
            end
            ST_DT2: begin
                w_mul_start = !r_issued;
                w_mul_a     = w_opd_dt;
                w_mul_b     = w_opd_dt;
            end
            ST_ALT: begin
                w_mul_start = !r_issued;
                w_mul_a     = OPD_W'(r_spd);
                w_mul_b     = w_opd_dt;
            end
            ST_AA1: begin
                w_mul_start = !r_issued;
                w_mul_a     = w_opd_dt;
                w_mul_b     = OPD_W'(r_pva) + OPD_W'(r_pav);
            end
            ST_AA2: begin
                w_mul_start = !r_issued;
                w_mul_a     = w_opd_dt2;
                w_mul_b     = OPD_W'(r_pvv);
            end
            ST_AA3: begin
                w_mul_start = !r_issued;
                w_mul_a     = $signed({{(OPD_W - 26){1'b0}}, w_qa});
                w_mul_b     = w_opd_dt;
            end
            ST_AVA: begin
                w_mul_start = !r_issued;
                w_mul_a     = w_opd_dt;
                w_mul_b     = OPD_W'(r_pvv);
            end
            ST_VV: begin
                w_mul_start = !r_issued;
                w_mul_a     = $signed({{(OPD_W - 26){1'b0}}, w_qv});
                w_mul_b     = w_opd_dt;
            end
            ST_C_ALT: begin
                w_mul_start = !r_issued;
                w_mul_a     = OPD_W'(r_k0);
                w_mul_b     = OPD_W'(r_innov);
            end
            ST_C_SPD: begin
                w_mul_start = !r_issued;
                w_mul_a     = OPD_W'(r_k1);
                w_mul_b     = OPD_W'(r_innov);
            end
            ST_C_VA: begin
                w_mul_start = !r_issued;
                w_mul_a     = OPD_W'(r_k1);
                w_mul_b     = OPD_W'(r_paa);
            end
            ST_C_VV: begin
                w_mul_start = !r_issued;
                w_mul_a     = OPD_W'(r_k1);
                w_mul_b     = OPD_W'(r_pav);
            end
            ST_C_AA: begin
                w_mul_start = !r_issued;
                w_mul_a     = OPD_W'(r_k0);
                w_mul_b     = OPD_W'(r_paa);
            end
            ST_C_AV: begin
                w_mul_start = !r_issued;
                w_mul_a     = OPD_W'(r_k0);
                w_mul_b     = OPD_W'(r_pav);
            end
            default: begin
                w_mul_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cfg_aqn   <= ALT_NOISE_RST;
            r_cfg_vqn   <= VEL_NOISE_RST;
            r_cfg_meas  <= MEAS_NOISE_RST;
            r_cfg_gate  <= GATE_RST;
            r_started   <= 1'b0;
            r_last_time <= '0;
            r_alt       <= '0;
            r_spd       <= '0;
            r_paa       <= COV_RST;
            r_pav       <= '0;
            r_pva       <= '0;
            r_pvv       <= COV_RST;
            r_innov     <= '0;
            r_rej       <= 1'b0;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_wr_en) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_ALT_NOISE:  r_cfg_aqn  <= i_cfg_data[22:0];
                    CFG_VEL_NOISE:  r_cfg_vqn  <= i_cfg_data[22:0];
                    CFG_MEAS_NOISE: r_cfg_meas <= i_cfg_data;
                    CFG_GATE:       r_cfg_gate <= i_cfg_data;
                    default: ;
                endcase
            end

            if (w_mul_start || w_div_start) r_issued <= 1'b1;
            if (w_mul_done || w_div_done) r_issued <= 1'b0;

            if (w_accept) r_smp <= i_sample.payload;

            if ((r_state == ST_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_START: begin
                    if (!r_started) begin
                        if (r_smp.baro_valid) begin
                            r_alt       <= r_smp.baro_altitude;
                            r_spd       <= '0;
                            r_started   <= 1'b1;
                            r_last_time <= r_smp.timestamp_us;
                        end
                    end else begin
                        r_last_time <= r_smp.timestamp_us;
                        r_delta     <= w_delta[DELTA_W-1:0];
                    end
                end
                ST_DT_DIV: r_dt <= w_dt_prod[DT_SHIFT +: DT_W];
                ST_DT2:    if (w_mul_done) r_dt2 <= w_mul_res[DT_W-1:0];
                ST_ALT:    if (w_mul_done) r_alt <= sat32(ACC_W'(r_alt) + w_mul_res);
                ST_AA1:    if (w_mul_done) r_acc <= ACC_W'(r_paa) + w_mul_res;
                ST_AA2:    if (w_mul_done) r_acc <= r_acc + w_mul_res;
                ST_AA3:    if (w_mul_done) r_paa <= sat32(r_acc + w_mul_res);
                ST_AVA: begin
                    if (w_mul_done) begin
                        r_pav <= sat32(ACC_W'(r_pav) + w_mul_res);
                        r_pva <= sat32(ACC_W'(r_pva) + w_mul_res);
                    end
                end
                ST_VV: if (w_mul_done) r_pvv <= sat32(ACC_W'(r_pvv) + w_mul_res);
                ST_CORR: begin
                    if (r_smp.baro_valid) begin
                        r_innov <= sat32(ACC_W'($signed(r_smp.baro_altitude)) - ACC_W'(r_alt));
                    end else begin
                        r_innov <= '0;
                        r_rej   <= 1'b0;
                    end
                end
                ST_GATE: begin
                    r_rej <= w_rej;
                    r_s   <= w_s;
                end
                ST_K0_DIV: if (w_div_done) r_k0 <= gain_from_quot(w_div_quot, r_paa[31]);
                ST_K1_DIV: if (w_div_done) r_k1 <= gain_from_quot(w_div_quot, r_pva[31]);
                ST_C_ALT:  if (w_mul_done) r_alt <= sat32(ACC_W'(r_alt) + w_mul_res);
                ST_C_SPD:  if (w_mul_done) r_spd <= sat32(ACC_W'(r_spd) + w_mul_res);
                ST_C_VA:   if (w_mul_done) r_pva <= sat32(ACC_W'(r_pva) - w_mul_res);
                ST_C_VV:   if (w_mul_done) r_pvv <= sat32(ACC_W'(r_pvv) - w_mul_res);
                ST_C_AA:   if (w_mul_done) r_paa <= sat32(ACC_W'(r_paa) - w_mul_res);
                ST_C_AV:   if (w_mul_done) r_pav <= sat32(ACC_W'(r_pav) - w_mul_res);
                ST_OUT: begin
                    if (w_out_free) begin
                        r_out.altitude       <= r_alt;
                        r_out.vertical_speed <= r_spd;
                        r_out.estimate_valid <= r_smp.sensor_ok && !r_smp.failsafe;
                        r_out.filter_started <= r_started;
                        r_out.innovation     <= r_innov;
                        r_out.rejected       <= r_rej;
                    end
                end
                default: ;
            endcase
        end
    end

    assign i_sample.ready  = (r_state == ST_IDLE);
    assign o_result.valid  = r_out_valid;
    assign o_result.payload = r_out;

endmodule

`default_nettype wire

@@ hw/rtl/bakf_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bakf_mul
    import bakf_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_start,
    input  wire signed [OPD_W-1:0]  i_a,
    input  wire signed [OPD_W-1:0]  i_b,
    output logic                    o_done,
    output logic signed [ACC_W-1:0] o_res
);

    logic [PROD_W-1:0]       r_prod;
    logic                    r_neg;
    logic                    r_stage1;
    logic signed [ACC_W-1:0] r_res;
    logic                    r_done;

    logic [OPD_W-1:0]  w_mag_a;
    logic [OPD_W-1:0]  w_mag_b;
    logic [PROD_W-1:0] w_round;
    logic [ACC_W-1:0]  w_mag_res;

    assign w_mag_a   = i_a[OPD_W-1] ? OPD_W'(-i_a) : OPD_W'(i_a);
    assign w_mag_b   = i_b[OPD_W-1] ? OPD_W'(-i_b) : OPD_W'(i_b);
    assign w_round   = (r_prod + (PROD_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    assign w_mag_res = w_round[ACC_W-1:0];

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(w_mag_a) * PROD_W'(w_mag_b);
        r_neg  <= i_a[OPD_W-1] ^ i_b[OPD_W-1];
        r_res  <= r_neg ? -$signed(w_mag_res) : $signed(w_mag_res);
        if (!i_rst_n) begin
            r_stage1 <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_stage1 <= i_start;
            r_done   <= r_stage1;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

`default_nettype wire

@@ hw/rtl/bakf_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bakf_div
    import bakf_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    input  wire [DIV_NUM_W-1:0]  i_num,
    input  wire [DIV_DEN_W-1:0]  i_den,
    output logic                 o_done,
    output logic [DIV_NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic [DIV_DEN_W:0]   r_rem;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W-1:0] r_den;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DIV_DEN_W:0] w_rem_sh;
    logic               w_ge;

    // Restoring division, one quotient bit per cycle.
    assign w_rem_sh = {r_rem[DIV_DEN_W-1:0], r_quo[DIV_NUM_W-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_NUM_W);
                r_rem  <= '0;
                r_quo  <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_rem_sh - {1'b0, r_den} : w_rem_sh;
                r_quo <= {r_quo[DIV_NUM_W-2:0], w_ge};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

`default_nettype wire

@@ hw/rtl/bakf_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bakf_checker
    import bakf_pkg::*;
(
    input wire          i_clk,
    input wire          i_rst_n,
    input wire          i_in_valid,
    input wire          i_in_ready,
    input wire          i_out_valid,
    input wire          i_out_ready,
    input wire t_result i_out_payload
);

    logic r_seen_started;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_started <= 1'b0;
        end else if (i_out_valid && i_out_ready && i_out_payload.filter_started) begin
            r_seen_started <= 1'b1;
        end
    end

    // A stalled result request holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_payload))
        else $error("result changed while stalled");

    // The filter works on one sample at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("sample taken while busy");

    // Once seeded, the filter stays seeded.
    a_started_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_seen_started |-> i_out_payload.filter_started)
        else $error("filter lost its seed");

    // Before seeding there is no innovation and nothing is rejected.
    a_unseeded_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_payload.filter_started |->
            (i_out_payload.innovation == 32'sd0) && !i_out_payload.rejected)
        else $error("innovation reported before seeding");

endmodule

bind baro_altitude_kalman_filter_core bakf_checker u_bakf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_sample.valid),
    .i_in_ready    (i_sample.ready),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_out_payload (o_result.payload)
);

`default_nettype wire

@@ tb/baro_altitude_kalman_filter_core_tb.sv @@
`timescale 1ns / 1ps

module baro_altitude_kalman_filter_core_tb;
    import bakf_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bakf_stream_if #(.t_payload(t_sample)) sample_if ();
    bakf_stream_if #(.t_payload(t_result)) result_if ();

    baro_altitude_kalman_filter_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (sample_if),
        .o_result    (result_if)
    );

    // Filter state held by the predictor.
    logic [22:0]        alt_noise_reg, vel_noise_reg;
    logic [25:0]        meas_noise_reg, gate_reg;
    logic               flt_started, flt_rejected;
    logic [31:0]        flt_last_time;
    logic signed [31:0] flt_alt, flt_speed, flt_innov;
    logic signed [31:0] p_aa, p_av, p_va, p_vv;

    t_sample pending_samples[$];
    t_result expected_results[$];

    int unsigned send_idle_pct, recv_idle_pct;
    bit          hold_sender;
    int          mismatches;
    int          samples_sent;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic longint sat_to_32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint fx_mul(input longint a, input longint b);
        longint unsigned ma, mb, p;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        p = (ma * mb + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint fx_div(input longint num, input longint den);
        longint unsigned n, q;
        n = ((num < 0) ? -num : num) << FRAC_BITS;
        q = (n + den / 2) / den;
        if (q > 64'h80000000) q = 64'h80000000;
        return sat_to_32((num < 0) ? -longint'(q) : longint'(q));
    endfunction

    function automatic longint clamp_reg(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [25:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        case (idx)
            CFG_ALT_NOISE:  alt_noise_reg  = value[22:0];
            CFG_VEL_NOISE:  vel_noise_reg  = value[22:0];
            CFG_MEAS_NOISE: meas_noise_reg = value;
            default:        gate_reg       = value;
        endcase
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic t_result filter_step(input t_sample s);
        t_result r;
        logic [31:0] delta;
        longint dt, dt2, qa, qv, rn, gate, sv, k0, k1, o_aa, o_av;
        longint n00, n01, n10, n11;
        if (!flt_started) begin
            if (s.baro_valid) begin
                flt_alt = s.baro_altitude;
                flt_speed = 0;
                flt_started = 1'b1;
                flt_last_time = s.timestamp_us;
            end
        end else begin
            delta = s.timestamp_us - flt_last_time;
            flt_last_time = s.timestamp_us;
            if (delta != 0 && delta <= 32'd1000000) begin
                dt = ((longint'(delta) << FRAC_BITS) + 500000) / 1000000;
                qa = clamp_reg(alt_noise_reg, 7, 6553600);
                qv = clamp_reg(vel_noise_reg, 7, 6553600);
                dt2 = fx_mul(dt, dt);
                flt_alt = sat_to_32(longint'(flt_alt) + fx_mul(flt_speed, dt));
                n00 = longint'(p_aa) + fx_mul(dt, longint'(p_va) + p_av)
                    + fx_mul(dt2, p_vv) + fx_mul(qa, dt);
                n01 = longint'(p_av) + fx_mul(dt, p_vv);
                n10 = longint'(p_va) + fx_mul(dt, p_vv);
                n11 = longint'(p_vv) + fx_mul(qv, dt);
                p_aa = sat_to_32(n00);
                p_av = sat_to_32(n01);
                p_va = sat_to_32(n10);
                p_vv = sat_to_32(n11);
            end
            if (s.baro_valid) begin
                gate = clamp_reg(gate_reg, 6554, 65536000);
                rn = clamp_reg(meas_noise_reg, 7, 65536000);
                flt_innov = sat_to_32(longint'(s.baro_altitude) - flt_alt);
                flt_rejected = ((flt_innov < 0) ? -longint'(flt_innov)
                                                : longint'(flt_innov)) > gate;
                sv = longint'(p_aa) + rn;
                if (!flt_rejected && sv > 0) begin
                    k0 = fx_div(p_aa, sv);
                    k1 = fx_div(p_va, sv);
                    flt_alt = sat_to_32(longint'(flt_alt) + fx_mul(k0, flt_innov));
                    flt_speed = sat_to_32(longint'(flt_speed) + fx_mul(k1, flt_innov));
                    o_aa = p_aa;
                    o_av = p_av;
                    p_aa = sat_to_32(o_aa - fx_mul(k0, o_aa));
                    p_av = sat_to_32(o_av - fx_mul(k0, o_av));
                    p_va = sat_to_32(longint'(p_va) - fx_mul(k1, o_aa));
                    p_vv = sat_to_32(longint'(p_vv) - fx_mul(k1, o_av));
                end
            end else begin
                flt_innov = 0;
                flt_rejected = 1'b0;
            end
        end
        r.altitude = flt_alt;
        r.vertical_speed = flt_speed;
        r.estimate_valid = s.sensor_ok && !s.failsafe;
        r.filter_started = flt_started;
        r.innovation = flt_innov;
        r.rejected = flt_rejected;
        return r;
    endfunction

    // Driver: a request is held until it is taken, then the next one follows.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sample_if.valid <= 1'b0;
        end else begin
            if (sample_if.valid && sample_if.ready) begin
                expected_results.push_back(filter_step(sample_if.payload));
                samples_sent++;
            end
            if (!(sample_if.valid && !sample_if.ready)) begin
                if (pending_samples.size() > 0 && !hold_sender &&
                    $urandom_range(99) >= send_idle_pct) begin
                    sample_if.payload <= pending_samples.pop_front();
                    sample_if.valid <= 1'b1;
                end else begin
                    sample_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
        end else begin
            if (result_if.valid && result_if.ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("Unexpected result %p", result_if.payload);
                end else if (result_if.payload !== expected_results[0]) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Mismatch: expected %p", expected_results[0]);
                        $display("          actual   %p", result_if.payload);
                    end
                    void'(expected_results.pop_front());
                end else begin
                    void'(expected_results.pop_front());
                end
            end
            result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic queue_sample(input logic [31:0] ts, input logic [31:0] alt,
                                input bit bv, input bit ok, input bit fs);
        t_sample s;
        s.timestamp_us = ts;
        s.baro_altitude = alt;
        s.baro_valid = bv;
        s.sensor_ok = ok;
        s.failsafe = fs;
        pending_samples.push_back(s);
    endtask

    task automatic drain;
        while (pending_samples.size() > 0 || sample_if.valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (250) @(posedge i_clk);
    endtask

    // A flight-like track: mostly small steps and a random walk in altitude, with noise.
    task automatic queue_flight(input int count, inout logic [31:0] ts);
        int alt;
        alt = $signed($urandom_range(2000000)) - 1000000;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(19))
                0: ts = ts + $urandom_range(3000000, 1000001);
                1: ts = ts;
                2: ts = $urandom;
                3: ts = ts + 1000000;
                default: ts = ts + $urandom_range(20000, 1);
            endcase
            if ($urandom_range(19) == 0) begin
                queue_sample(ts, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)),
                             1'($urandom_range(1)));
            end else begin
                alt = alt + $signed($urandom_range(40000)) - 20000;
                if ($urandom_range(9) == 0) alt = alt + $signed($urandom_range(4000000)) - 2000000;
                queue_sample(ts, alt, $urandom_range(7) != 0, $urandom_range(7) != 0,
                             $urandom_range(7) == 0);
            end
        end
    endtask

    initial begin
        logic [31:0] ts;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = CFG_ALT_NOISE;
        i_cfg_data = '0;
        sample_if.valid = 1'b0;
        sample_if.payload = '0;
        result_if.ready = 1'b0;
        send_idle_pct = 28;
        recv_idle_pct = 79;
        hold_sender = 0;
        mismatches = 0;
        samples_sent = 0;
        alt_noise_reg = ALT_NOISE_RST;
        vel_noise_reg = VEL_NOISE_RST;
        meas_noise_reg = MEAS_NOISE_RST;
        gate_reg = GATE_RST;
        flt_started = 0;
        flt_rejected = 0;
        flt_last_time = 0;
        flt_alt = 0;
        flt_speed = 0;
        flt_innov = 0;
        p_aa = COV_RST;
        p_av = 0;
        p_va = 0;
        p_vv = COV_RST;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: an unseeded invalid sample, seeding, zero and oversized gaps,
        // the largest accepted gap, wrap, gate rejection and extreme altitudes.
        queue_sample(32'd5, 32'h7FFFFFFF, 0, 1, 0);
        queue_sample(32'd100, 32'h00010000, 1, 1, 0);
        queue_sample(32'd100, 32'h00010000, 1, 1, 1);
        queue_sample(32'd10100, 32'h00018000, 1, 0, 0);
        queue_sample(32'd1010100, 32'h00020000, 1, 1, 0);
        queue_sample(32'd2010101, 32'h00020000, 1, 1, 0);
        queue_sample(32'd2020101, 32'h00200000, 1, 1, 0);
        queue_sample(32'd2030101, 32'h00020000, 0, 1, 0);
        queue_sample(32'hFFFFFF00, 32'h80000000, 1, 1, 0);
        queue_sample(32'h00000F00, 32'h7FFFFFFF, 1, 0, 1);
        queue_sample(32'h00001F00, 32'hFFFFFFFF, 1, 1, 0);
        queue_sample(32'h00002000, 32'h00000000, 1, 1, 0);
        queue_sample(32'h00002001, 32'h00000001, 1, 1, 0);
        drain();

        // Extremes of every register, then a flight on each setting.
        write_reg(CFG_ALT_NOISE, 26'h3FFFFFF);
        write_reg(CFG_VEL_NOISE, 26'd0);
        write_reg(CFG_MEAS_NOISE, 26'h3FFFFFF);
        write_reg(CFG_GATE, 26'd0);
        ts = 32'h00003000;
        queue_flight(60, ts);
        drain();
        write_reg(CFG_ALT_NOISE, 26'd6553600);
        write_reg(CFG_VEL_NOISE, 26'd6553600);
        write_reg(CFG_MEAS_NOISE, 26'd7);
        write_reg(CFG_GATE, 26'd65536000);
        queue_flight(120, ts);
        drain();
        write_reg(CFG_ALT_NOISE, 26'd7);
        write_reg(CFG_VEL_NOISE, 26'd7);
        write_reg(CFG_MEAS_NOISE, 26'd65536000);
        write_reg(CFG_GATE, 26'd6554);
        queue_flight(120, ts);
        drain();

        send_idle_pct = 79;
        recv_idle_pct = 28;
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_ALT_NOISE, 26'($urandom));
            write_reg(CFG_VEL_NOISE, 26'($urandom));
            write_reg(CFG_MEAS_NOISE, 26'($urandom));
            write_reg(CFG_GATE, 26'($urandom_range(3000000)));
            queue_flight(90, ts);
            if (ph == 2) begin
                // The sender stands back until every outstanding result is in.
                while (pending_samples.size() > 45) @(posedge i_clk);
                hold_sender = 1;
                while (sample_if.valid || expected_results.size() > 0) @(posedge i_clk);
                hold_sender = 0;
            end
            drain();
        end

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_ALT_NOISE, 26'(ALT_NOISE_RST));
        write_reg(CFG_VEL_NOISE, 26'(VEL_NOISE_RST));
        write_reg(CFG_MEAS_NOISE, MEAS_NOISE_RST);
        write_reg(CFG_GATE, GATE_RST);
        queue_flight(400, ts);
        drain();

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
